/* rtl/fwbp_pkg.sv */
// Package for the fixed-width bit packer: widths, register indexes and the
// queue entry and result types. No dependencies.
`default_nettype none

package fwbp_pkg;

	localparam int WORD_BITS   = 32;
	localparam int MAX_WORDS   = 4096;
	localparam int WIDTH_BITS  = 6;   // bit_width register and valid_bits field
	localparam int FILL_BITS   = 5;   // bits held in the partial word, 0..31
	localparam int CAP_BITS    = 13;  // capacity register and word counter
	localparam int INDEX_BITS  = 12;  // word_index field
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = 2;
	localparam int QCNT_BITS   = 3;

	// Configuration register indexes
	typedef enum logic {
		REG_BIT_WIDTH = 1'b0,
		REG_CAPACITY  = 1'b1
	} cfg_reg_t;

	// One classified item, as held in the queue
	typedef struct packed {
		logic [WORD_BITS-1:0]  value;  // already masked to the width
		logic [WIDTH_BITS-1:0] width;  // clamped to 1..32
		logic                  last;
	} item_t;

	// Queue head as seen by the back end
	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

	// One result transaction
	typedef struct packed {
		logic [WORD_BITS-1:0]  word;
		logic [INDEX_BITS-1:0] index;
		logic [WIDTH_BITS-1:0] valid_bits;
		logic                  overflow;
		logic                  fin;
	} result_t;

endpackage

`default_nettype wire

/* rtl/fwbp_front.sv */
// Front end of the bit packer: configuration registers, width clamp and
// value masking. Depends on fwbp_pkg.
`default_nettype none

module fwbp_front (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic                              cfg_index,
	input  wire logic [fwbp_pkg::CAP_BITS-1:0]     cfg_data,
	input  wire logic                              in_valid,
	input  wire logic [fwbp_pkg::WORD_BITS-1:0]    value,
	input  wire logic                              is_last,
	input  wire logic                              queue_full,
	output logic                                   in_stall,
	output logic                                   push,
	output fwbp_pkg::item_t                        push_item,
	output logic [fwbp_pkg::CAP_BITS-1:0]          limit
);

	logic [fwbp_pkg::WIDTH_BITS-1:0] bit_width_q;
	logic [fwbp_pkg::CAP_BITS-1:0]   capacity_q;
	logic [fwbp_pkg::WIDTH_BITS-1:0] width_eff;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_width_q <= fwbp_pkg::WIDTH_BITS'(fwbp_pkg::WORD_BITS);
			capacity_q  <= fwbp_pkg::CAP_BITS'(fwbp_pkg::MAX_WORDS);
		end else if (cfg_wr_en) begin
			unique case (fwbp_pkg::cfg_reg_t'(cfg_index))
				fwbp_pkg::REG_BIT_WIDTH: bit_width_q <= cfg_data[fwbp_pkg::WIDTH_BITS-1:0];
				fwbp_pkg::REG_CAPACITY:  capacity_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Word limit is the smaller of the register and the array size
	always_comb begin
		if (capacity_q > fwbp_pkg::CAP_BITS'(fwbp_pkg::MAX_WORDS))
			limit = fwbp_pkg::CAP_BITS'(fwbp_pkg::MAX_WORDS);
		else
			limit = capacity_q;
	end

	// Clamp width to 1..32
	always_comb begin
		if (bit_width_q == '0)
			width_eff = fwbp_pkg::WIDTH_BITS'(1);
		else if (bit_width_q > fwbp_pkg::WIDTH_BITS'(fwbp_pkg::WORD_BITS))
			width_eff = fwbp_pkg::WIDTH_BITS'(fwbp_pkg::WORD_BITS);
		else
			width_eff = bit_width_q;
	end

	// Classify and push; a shift of 32 yields a full mask
	always_comb begin
		push_item.value = value & ~({fwbp_pkg::WORD_BITS{1'b1}} << width_eff);
		push_item.width = width_eff;
		push_item.last  = is_last;
	end

	assign in_stall = queue_full;
	assign push     = in_valid && !queue_full;

endmodule

`default_nettype wire

/* rtl/fwbp_queue.sv */
// Short item queue between the front and back ends of the bit packer.
// Depends on fwbp_pkg.
`default_nettype none

module fwbp_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire fwbp_pkg::item_t push_item,
	input  wire logic            pop,
	output logic                 full,
	output fwbp_pkg::head_t      head
);

	fwbp_pkg::item_t                 entries_q [fwbp_pkg::QUEUE_DEPTH];
	logic [fwbp_pkg::QPTR_BITS-1:0]  wr_ptr_q;
	logic [fwbp_pkg::QPTR_BITS-1:0]  rd_ptr_q;
	logic [fwbp_pkg::QCNT_BITS-1:0]  count_q;
	logic                            do_pop;

	assign full   = (count_q == fwbp_pkg::QCNT_BITS'(fwbp_pkg::QUEUE_DEPTH));
	assign do_pop = pop && (count_q != '0);

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (!push && do_pop)
				count_q <= count_q - 1'b1;
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= push_item;
	end

	assign head.valid = (count_q != '0);
	assign head.item  = entries_q[rd_ptr_q];

endmodule

`default_nettype wire

/* rtl/fwbp_back.sv */
// Back end of the bit packer: stream state, word assembly, capacity check
// and the output register with a slot for a second result. Depends on fwbp_pkg.
`default_nettype none

module fwbp_back (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire fwbp_pkg::head_t                head,
	input  wire logic [fwbp_pkg::CAP_BITS-1:0]  limit,
	input  wire logic                           out_stall,
	output logic                                pop,
	output logic                                out_valid,
	output fwbp_pkg::result_t                   out_res
);

	// Stream state
	logic [fwbp_pkg::WORD_BITS-1:0] acc_q;
	logic [fwbp_pkg::FILL_BITS-1:0] fill_q;
	logic [fwbp_pkg::CAP_BITS-1:0]  idx_q;
	logic                           ovf_seen_q;

	logic [fwbp_pkg::WORD_BITS-1:0] acc_d;
	logic [fwbp_pkg::FILL_BITS-1:0] fill_d;
	logic [fwbp_pkg::CAP_BITS-1:0]  idx_d;
	logic                           ovf_seen_d;

	// Output register and second-result slot
	logic                out_valid_q;
	fwbp_pkg::result_t   out_q;
	logic                pend_valid_q;
	fwbp_pkg::result_t   pend_q;

	fwbp_pkg::result_t   res_a;
	fwbp_pkg::result_t   res_b;
	logic                has_a;
	logic                has_b;

	logic [fwbp_pkg::WIDTH_BITS-1:0] total;
	logic [fwbp_pkg::FILL_BITS-1:0]  rest;
	logic [fwbp_pkg::FILL_BITS-1:0]  sh_fill;
	logic [fwbp_pkg::FILL_BITS-1:0]  sh_rest;
	logic [fwbp_pkg::WIDTH_BITS-1:0] sh_fill_w;
	logic [fwbp_pkg::WIDTH_BITS-1:0] sh_rest_w;
	logic [fwbp_pkg::WORD_BITS-1:0]  acc_fill;
	logic [fwbp_pkg::WORD_BITS-1:0]  word_full;
	logic [fwbp_pkg::WORD_BITS-1:0]  acc_rest;
	logic [fwbp_pkg::CAP_BITS-1:0]   idx_next;
	logic                            ovf_a;
	logic                            ovf_b;
	logic                            fits;
	logic                            advance;
	logic                            take;

	// Handshake: output moves when empty or taken; the second result goes first
	assign advance = !out_valid_q || !out_stall;
	assign take    = advance && head.valid && !pend_valid_q;
	assign pop     = take;

	// Shift amounts and candidate words
	always_comb begin
		total     = {1'b0, fill_q} + head.item.width;
		fits      = !total[fwbp_pkg::WIDTH_BITS-1];
		rest      = total[fwbp_pkg::FILL_BITS-1:0];
		sh_fill_w = fwbp_pkg::WIDTH_BITS'(fwbp_pkg::WORD_BITS) - total;
		sh_rest_w = fwbp_pkg::WIDTH_BITS'(fwbp_pkg::WORD_BITS) - {1'b0, rest};
		sh_fill   = sh_fill_w[fwbp_pkg::FILL_BITS-1:0];
		sh_rest   = sh_rest_w[fwbp_pkg::FILL_BITS-1:0];
		acc_fill  = acc_q | (head.item.value << sh_fill);
		word_full = acc_q | (head.item.value >> rest);
		acc_rest  = (rest == '0) ? '0 : (head.item.value << sh_rest);
		ovf_a     = (idx_q >= limit);
		idx_next  = ovf_a ? idx_q : idx_q + 1'b1;
		ovf_b     = (idx_next >= limit);
	end

	// Results and next stream state for the head item
	always_comb begin
		acc_d      = acc_q;
		fill_d     = fill_q;
		idx_d      = idx_q;
		ovf_seen_d = ovf_seen_q;
		res_a      = '0;
		res_b      = '0;
		has_a      = 1'b0;
		has_b      = 1'b0;
		if (ovf_seen_q) begin
			// Dropping until the last item, which closes with an empty word
			if (head.item.last) begin
				res_a.index    = idx_q[fwbp_pkg::INDEX_BITS-1:0];
				res_a.overflow = 1'b1;
				res_a.fin      = 1'b1;
				has_a          = 1'b1;
				acc_d          = '0;
				fill_d         = '0;
				idx_d          = '0;
				ovf_seen_d     = 1'b0;
			end
		end else if (fits) begin
			if (head.item.last) begin
				// Partial word flush
				res_a.word       = acc_fill;
				res_a.index      = idx_q[fwbp_pkg::INDEX_BITS-1:0];
				res_a.valid_bits = total;
				res_a.overflow   = ovf_a;
				res_a.fin        = 1'b1;
				has_a            = 1'b1;
				acc_d            = '0;
				fill_d           = '0;
				idx_d            = '0;
				ovf_seen_d       = 1'b0;
			end else begin
				acc_d  = acc_fill;
				fill_d = total[fwbp_pkg::FILL_BITS-1:0];
			end
		end else begin
			// Word completes; the value may straddle into the next one
			res_a.word       = word_full;
			res_a.index      = idx_q[fwbp_pkg::INDEX_BITS-1:0];
			res_a.valid_bits = fwbp_pkg::WIDTH_BITS'(fwbp_pkg::WORD_BITS);
			res_a.overflow   = ovf_a;
			res_a.fin        = head.item.last && (rest == '0);
			has_a            = 1'b1;
			acc_d            = acc_rest;
			fill_d           = rest;
			idx_d            = idx_next;
			ovf_seen_d       = ovf_a;
			if (head.item.last) begin
				if (rest != '0) begin
					res_b.word       = acc_rest;
					res_b.index      = idx_next[fwbp_pkg::INDEX_BITS-1:0];
					res_b.valid_bits = {1'b0, rest};
					res_b.overflow   = ovf_b;
					res_b.fin        = 1'b1;
					has_b            = 1'b1;
				end
				acc_d      = '0;
				fill_d     = '0;
				idx_d      = '0;
				ovf_seen_d = 1'b0;
			end
		end
	end

	// Stream state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			fill_q     <= '0;
			idx_q      <= '0;
			ovf_seen_q <= 1'b0;
		end else if (take) begin
			acc_q      <= acc_d;
			fill_q     <= fill_d;
			idx_q      <= idx_d;
			ovf_seen_q <= ovf_seen_d;
		end
	end

	// Output control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (advance) begin
			if (pend_valid_q) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= take && has_a;
				pend_valid_q <= take && has_b;
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (advance) begin
			if (pend_valid_q) begin
				out_q <= pend_q;
			end else if (take) begin
				out_q  <= res_a;
				pend_q <= res_b;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

endmodule

`default_nettype wire

/* rtl/fixed_width_bit_packer_core.sv */
// Top level of the fixed-width bit packer: front end, item queue and back end.
// Depends on fwbp_pkg, fwbp_front, fwbp_queue and fwbp_back.
//
//   channel  | direction | handshake         | payload
//   ---------+-----------+-------------------+------------------------------------------
//   in       | in        | in_valid/in_stall | value, is_last
//   out      | out       | out_valid/out_stall| packed_word, word_index, valid_bits,
//            |           |                   | overflow, is_final
//   cfg      | in        | cfg_wr_en         | cfg_index, cfg_data
//
// One item per cycle sustained while out_stall is low; an item that makes two
// words (a straddle on the last item) holds the back end while the second
// output is sent. An input transaction passes through the four-entry queue
// and then the output register on its way to the first result.
// in_stall rises only when the queue is full; out_stall backs up into the queue.
// Reset clears the stream state and sets bit_width to 32, capacity to 4096.
`default_nettype none

module fixed_width_bit_packer_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_wr_en,
	input  wire logic                                cfg_index,
	input  wire logic [fwbp_pkg::CAP_BITS-1:0]       cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [fwbp_pkg::WORD_BITS-1:0]      value,
	input  wire logic                                is_last,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [fwbp_pkg::WORD_BITS-1:0]           packed_word,
	output logic [fwbp_pkg::INDEX_BITS-1:0]          word_index,
	output logic [fwbp_pkg::WIDTH_BITS-1:0]          valid_bits,
	output logic                                     overflow,
	output logic                                     is_final
);

	logic                                queue_full;
	logic                                push;
	fwbp_pkg::item_t                     push_item;
	logic [fwbp_pkg::CAP_BITS-1:0]       limit;
	logic                                pop;
	fwbp_pkg::head_t                     head;
	fwbp_pkg::result_t                   out_res;

	fwbp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.value      (value),
		.is_last    (is_last),
		.queue_full (queue_full),
		.in_stall   (in_stall),
		.push       (push),
		.push_item  (push_item),
		.limit      (limit)
	);

	fwbp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.full      (queue_full),
		.head      (head)
	);

	fwbp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.limit     (limit),
		.out_stall (out_stall),
		.pop       (pop),
		.out_valid (out_valid),
		.out_res   (out_res)
	);

	// Result fields
	assign packed_word = out_res.word;
	assign word_index  = out_res.index;
	assign valid_bits  = out_res.valid_bits;
	assign overflow    = out_res.overflow;
	assign is_final    = out_res.fin;

endmodule

`default_nettype wire
